// ===== src/alfr_pkg.sv =====
package alfr_pkg;

  localparam int DEGREE_DEF     = 31;
  localparam int SEPARATION_DEF = 3;

  localparam int WORD_W = 32;
  localparam int OUT_W  = 31;

  // request kinds carried in tuser
  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_NEXT   = 1'b1;

  // minimal standard step constants
  localparam logic [31:0] PM_MULT     = 32'd16807;
  localparam logic [31:0] PM_QUOT     = 32'd127773;
  localparam logic [31:0] PM_REM      = 32'd2836;
  localparam logic [33:0] PM_MOD      = 34'h07fffffff;
  localparam logic [31:0] PM_ZERO_SUB = 32'd123459876;

  // floor(2^48 / 127773), quotient estimate is low by at most one
  localparam logic [63:0] PM_RECIP_FULL = (64'd1 << 48) / 64'd127773;
  localparam logic [31:0] PM_RECIP      = PM_RECIP_FULL[31:0];

  typedef struct packed {
    logic seed_wr;
    logic pm_wr;
    logic rd;
    logic adv;
    logic emit;
  } alfr_cmd_t;

  typedef struct packed {
    logic word_last;
    logic out_free;
  } alfr_sts_t;

  function automatic logic [31:0] default_word(input logic [31:0] idx);
    logic [31:0] w;
    case (idx)
      32'd0:  w = 32'h991539b1;
      32'd1:  w = 32'h16a5bce3;
      32'd2:  w = 32'h6774a4cd;
      32'd3:  w = 32'h3e01511e;
      32'd4:  w = 32'h4e508aaa;
      32'd5:  w = 32'h61048c05;
      32'd6:  w = 32'hf5500617;
      32'd7:  w = 32'h846b7115;
      32'd8:  w = 32'h6a19892c;
      32'd9:  w = 32'h896a97af;
      32'd10: w = 32'hdb48f936;
      32'd11: w = 32'h14898454;
      32'd12: w = 32'h37ffd106;
      32'd13: w = 32'hb58bff9c;
      32'd14: w = 32'h59e17104;
      32'd15: w = 32'hcf918a49;
      32'd16: w = 32'h09378c83;
      32'd17: w = 32'h52c7a471;
      32'd18: w = 32'h8d293ea9;
      32'd19: w = 32'h1f4fc301;
      32'd20: w = 32'hc3db71be;
      32'd21: w = 32'h39b44e1c;
      32'd22: w = 32'hf8a44ef9;
      32'd23: w = 32'h4c8b80b1;
      32'd24: w = 32'h19edc328;
      32'd25: w = 32'h87bf4bdd;
      32'd26: w = 32'hc9b240e5;
      32'd27: w = 32'he9ee4b1b;
      32'd28: w = 32'h4382aee7;
      32'd29: w = 32'h535b6b41;
      32'd30: w = 32'hf3bec5da;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

// ===== src/additive_lagged_fibonacci_rng.sv =====
// next request: table words are read while idle, then added and written back in the write state once
// the output is free, result registered there; no new item is taken until the write is done
// reseed request: busy, no result; the seed becomes word 0, each further fill word runs the
// step pipeline, each discarded output a read state and then a write state
// reset: synchronous, table reads as the default words until written, indices return to
// separation and 0
module additive_lagged_fibonacci_rng #(
  parameter int DEGREE     = alfr_pkg::DEGREE_DEF,
  parameter int SEPARATION = alfr_pkg::SEPARATION_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // seed_value[31:0]
  input  logic        s_axis_tuser,   // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // random_value[30:0], zero [31]
);
  import alfr_pkg::*;

  alfr_cmd_t   cmd;
  alfr_sts_t   sts;
  logic [30:0] random_value;

  alfr_ctrl #(
    .DEGREE(DEGREE)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_op   (s_axis_tuser),
    .cmd     (cmd),
    .sts     (sts)
  );

  alfr_dp #(
    .DEGREE    (DEGREE),
    .SEPARATION(SEPARATION)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .seed     (s_axis_tdata),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (random_value)
  );

  assign m_axis_tdata = {1'b0, random_value};

endmodule

// ===== src/alfr_ram.sv =====
module alfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== src/alfr_dp.sv =====
module alfr_dp #(
  parameter int DEGREE     = 31,
  parameter int SEPARATION = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  alfr_pkg::alfr_cmd_t cmd,
  output alfr_pkg::alfr_sts_t sts,
  input  logic [31:0]         seed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [30:0]         out_data
);
  import alfr_pkg::*;

  localparam int IW = $clog2(DEGREE);
  localparam logic [IW-1:0] SEP_M   = IW'(SEPARATION % DEGREE);
  localparam logic [IW-1:0] LAST_IX = IW'(DEGREE - 1);

  logic [IW-1:0]     front;
  logic [IW-1:0]     rear;
  logic [IW-1:0]     word_idx;
  logic [DEGREE-1:0] vld;
  logic [31:0]       prev;

  // read side
  logic [IW-1:0] fa_q;
  logic [IW-1:0] ra_q;
  logic          vf_q;
  logic          vr_q;
  logic [31:0]   ram_a;
  logic [31:0]   ram_b;
  logic [31:0]   word_f;
  logic [31:0]   word_r;
  logic [31:0]   sum;

  // write side
  logic          we;
  logic [IW-1:0] waddr;
  logic [31:0]   wdata;

  // minimal standard step pipeline
  logic [31:0] xs;
  logic [31:0] m_abs;
  logic [31:0] m1;
  logic        neg1;
  logic [63:0] prod_q;
  logic [31:0] m2;
  logic [15:0] q2;
  logic        neg2;
  logic [33:0] r_full;
  logic [17:0] r3;
  logic [15:0] q3;
  logic        neg3;
  logic [16:0] r4;
  logic [15:0] q4;
  logic        neg4;
  logic [31:0] pa5;
  logic [31:0] pb5;
  logic        neg5;
  logic signed [33:0] t_raw;
  logic signed [33:0] t_fix;
  logic [31:0] pm_word;

  function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] idx);
    return (idx == LAST_IX) ? '0 : idx + IW'(1);
  endfunction

  alfr_ram #(
    .WIDTH(32),
    .DEPTH(DEGREE)
  ) u_table (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (cmd.rd),
    .raddr_a(front),
    .raddr_b(rear),
    .rdata_a(ram_a),
    .rdata_b(ram_b)
  );

  // entries never written since reset read as the default table
  assign word_f = vf_q ? ram_a : default_word(32'(fa_q));
  assign word_r = vr_q ? ram_b : default_word(32'(ra_q));
  assign sum    = word_f + word_r;

  always_comb begin
    xs    = (prev == 32'd0) ? PM_ZERO_SUB : prev;
    m_abs = xs[31] ? (~xs + 32'd1) : xs;
    r_full = {2'b00, m2} - 34'(q2) * 34'(PM_QUOT);
    if (neg5) begin
      t_raw = $signed({2'b00, pb5}) - $signed({2'b00, pa5});
    end else begin
      t_raw = $signed({2'b00, pa5}) - $signed({2'b00, pb5});
    end
    t_fix   = (t_raw < 0) ? t_raw + $signed(PM_MOD) : t_raw;
    pm_word = t_fix[31:0];
  end

  always_comb begin
    we    = cmd.seed_wr | cmd.pm_wr | cmd.adv;
    waddr = front;
    wdata = sum;
    if (cmd.seed_wr) begin
      waddr = '0;
      wdata = seed;
    end else if (cmd.pm_wr) begin
      waddr = word_idx;
      wdata = pm_word;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    m1     <= m_abs;
    neg1   <= xs[31];
    prod_q <= 64'(m1) * 64'(PM_RECIP);
    m2     <= m1;
    q2     <= prod_q[63:48];
    neg2   <= neg1;
    r3     <= r_full[17:0];
    q3     <= q2;
    neg3   <= neg2;
    if (r3 >= PM_QUOT[17:0]) begin
      r4 <= 17'(r3 - PM_QUOT[17:0]);
      q4 <= q3 + 16'd1;
    end else begin
      r4 <= r3[16:0];
      q4 <= q3;
    end
    neg4 <= neg3;
    pa5  <= PM_MULT * 32'(r4);
    pb5  <= PM_REM * 32'(q4);
    neg5 <= neg4;
    if (cmd.seed_wr) begin
      prev <= seed;
    end else if (cmd.pm_wr) begin
      prev <= pm_word;
    end
    if (cmd.rd) begin
      fa_q <= front;
      ra_q <= rear;
    end
    if (cmd.emit) begin
      out_data <= sum[31:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= SEP_M;
      rear      <= '0;
      word_idx  <= '0;
      vld       <= '0;
      vf_q      <= 1'b0;
      vr_q      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (cmd.rd) begin
        vf_q <= vld[front];
        vr_q <= vld[rear];
      end
      if (cmd.seed_wr) begin
        front    <= SEP_M;
        rear     <= '0;
        word_idx <= IW'(1);
      end else if (cmd.adv) begin
        front <= step_idx(front);
        rear  <= step_idx(rear);
      end
      if (cmd.pm_wr) begin
        word_idx <= word_idx + IW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.word_last = (word_idx == LAST_IX);
  assign sts.out_free  = ~out_valid | out_ready;

  // front always leads rear by the separation, modulo the degree
  logic [IW:0] rear_sep;
  logic [IW:0] rear_lead;
  assign rear_sep  = {1'b0, rear} + {1'b0, SEP_M};
  assign rear_lead = (rear_sep >= (IW + 1)'(DEGREE)) ? rear_sep - (IW + 1)'(DEGREE) : rear_sep;

  a_index_gap: assert property (@(posedge clk) disable iff (rst)
    {1'b0, front} == rear_lead)
    else $error("front and rear indices lost their separation");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.seed_wr, cmd.pm_wr, cmd.adv}))
    else $error("two table writers in one cycle");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result raised without an emit");

endmodule

// ===== src/alfr_ctrl.sv =====
module alfr_ctrl #(
  parameter int DEGREE = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  output alfr_pkg::alfr_cmd_t cmd,
  input  alfr_pkg::alfr_sts_t sts
);
  import alfr_pkg::*;

  localparam int DISCARD = 10 * DEGREE;
  localparam int DW      = $clog2(DISCARD);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NXT_WR,
    S_PM_ABS,
    S_PM_MUL,
    S_PM_SUB,
    S_PM_FIX,
    S_PM_PROD,
    S_PM_SCALE,
    S_PM_WR,
    S_DIS_RD,
    S_DIS_WR
  } state_t;

  state_t        state;
  logic [DW-1:0] disc_cnt;

  always_comb begin
    cmd      = '0;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        // table words for a next request are fetched while waiting
        cmd.rd      = 1'b1;
        cmd.seed_wr = in_valid & (in_op == OP_RESEED);
      end
      S_NXT_WR: begin
        cmd.adv  = sts.out_free;
        cmd.emit = sts.out_free;
      end
      S_PM_WR:  cmd.pm_wr = 1'b1;
      S_DIS_RD: cmd.rd    = 1'b1;
      S_DIS_WR: cmd.adv   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      disc_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (in_op == OP_NEXT) ? S_NXT_WR : S_PM_ABS;
          end
        end
        S_NXT_WR: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        S_PM_ABS:   state <= S_PM_MUL;
        S_PM_MUL:   state <= S_PM_SUB;
        S_PM_SUB:   state <= S_PM_FIX;
        S_PM_FIX:   state <= S_PM_PROD;
        S_PM_PROD:  state <= S_PM_SCALE;
        // products registered here, the step word is ready in the write cycle
        S_PM_SCALE: state <= S_PM_WR;
        S_PM_WR: begin
          if (sts.word_last) begin
            state    <= S_DIS_RD;
            disc_cnt <= '0;
          end else begin
            state <= S_PM_ABS;
          end
        end
        S_DIS_RD: state <= S_DIS_WR;
        S_DIS_WR: begin
          if (disc_cnt == DW'(DISCARD - 1)) begin
            state <= S_IDLE;
          end else begin
            disc_cnt <= disc_cnt + DW'(1);
            state    <= S_DIS_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_leave_on_accept: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("left idle without an accepted item");

  a_disc_bound: assert property (@(posedge clk) disable iff (rst)
    disc_cnt < DW'(DISCARD))
    else $error("discard counter overran");

endmodule

// ===== test/tb_additive_lagged_fibonacci_rng.sv =====
`timescale 1ns / 1ps

module tb_additive_lagged_fibonacci_rng;
  import alfr_pkg::*;

  localparam int DEGREE     = DEGREE_DEF;
  localparam int SEPARATION = SEPARATION_DEF;
  localparam int DISCARDS   = 10 * DEGREE;

  localparam longint MS_MULT     = 16807;
  localparam longint MS_QUOT     = 127773;
  localparam longint MS_REM      = 2836;
  localparam longint MS_MOD      = 64'h7fffffff;
  localparam longint MS_ZERO_SUB = 123459876;

  localparam int PHASE_ITEMS = 542;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 8000;
  localparam int TAIL_CYCLES = 900;

  localparam logic [0:30][31:0] RESET_WORDS = {
    32'h991539b1, 32'h16a5bce3, 32'h6774a4cd, 32'h3e01511e, 32'h4e508aaa, 32'h61048c05,
    32'hf5500617, 32'h846b7115, 32'h6a19892c, 32'h896a97af, 32'hdb48f936, 32'h14898454,
    32'h37ffd106, 32'hb58bff9c, 32'h59e17104, 32'hcf918a49, 32'h09378c83, 32'h52c7a471,
    32'h8d293ea9, 32'h1f4fc301, 32'hc3db71be, 32'h39b44e1c, 32'hf8a44ef9, 32'h4c8b80b1,
    32'h19edc328, 32'h87bf4bdd, 32'hc9b240e5, 32'he9ee4b1b, 32'h4382aee7, 32'h535b6b41,
    32'hf3bec5da
  };

  typedef struct packed {
    logic        op;
    logic [31:0] seed;
    logic        known;
    logic [30:0] value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_NEXT;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  // generator state as the block should hold it
  logic [31:0] seq_table [DEGREE];
  int unsigned seq_front;
  int unsigned seq_rear;
  logic [30:0] expected_values [$];

  stim_row_t   probe_rows [$];
  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  logic        hold_req = 1'b0;
  int          error_count = 0;
  int          next_count = 0;
  int          reseed_count = 0;
  int          checked_count = 0;
  int          idle_cycles = 0;
  logic [30:0] want;

  additive_lagged_fibonacci_rng dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // minimal standard step on the word read as signed, truncating division
  function automatic logic [31:0] min_std_step(input logic [31:0] word);
    longint x;
    longint hi;
    longint lo;
    x = longint'($signed(word));
    if (x == 0) x = MS_ZERO_SUB;
    hi = x / MS_QUOT;
    lo = x % MS_QUOT;
    x = MS_MULT * lo - MS_REM * hi;
    if (x < 0) x = x + MS_MOD;
    return x[31:0];
  endfunction

  function automatic logic [30:0] lagged_sum();
    logic [31:0] sum;
    sum = seq_table[seq_front] + seq_table[seq_rear];
    seq_table[seq_front] = sum;
    seq_front = (seq_front + 1) % DEGREE;
    seq_rear = (seq_rear + 1) % DEGREE;
    return sum[31:1];
  endfunction

  task automatic reset_table();
    for (int i = 0; i < DEGREE; i++) seq_table[i] = (i < 31) ? RESET_WORDS[i] : 32'h0;
    seq_front = SEPARATION % DEGREE;
    seq_rear = 0;
  endtask

  task automatic reseed_table(input logic [31:0] seed);
    seq_table[0] = seed;
    for (int i = 1; i < DEGREE; i++) seq_table[i] = min_std_step(seq_table[i-1]);
    seq_front = SEPARATION % DEGREE;
    seq_rear = 0;
    for (int i = 0; i < DISCARDS; i++) void'(lagged_sum());
  endtask

  // entered and left at a falling edge
  task automatic offer_item(input logic op, input logic [31:0] seed, input logic known,
                            input logic [30:0] value);
    logic [30:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= seed;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == OP_NEXT) begin
      predicted = lagged_sum();
      expected_values.push_back(known ? value : predicted);
      next_count++;
    end else begin
      reseed_table(seed);
      reseed_count++;
    end
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(9))
      0: return $urandom_range(3);
      1: return 32'h7fffffff - $urandom_range(2);
      2: return 32'h80000000 + $urandom_range(2);
      3: return 32'hffffffff - $urandom_range(2);
      4: return 32'd127773 * $urandom_range(1, 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (expected_values.size() == 0);
    @(negedge clk);
  endtask

  task automatic random_phase(input int unsigned tx_idle, input int unsigned rx_idle);
    send_idle_pct = tx_idle;
    rcv_idle_pct = rx_idle;
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(19) == 0) offer_item(OP_RESEED, pick_seed(), 1'b0, '0);
      else offer_item(OP_NEXT, $urandom, 1'b0, '0);
    end
    drain();
  endtask

  // output side: random back-pressure plus one long hold when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_values.pop_front();
        checked_count++;
        if (m_axis_tdata[30:0] !== want) begin
          $display("%0t: random_value expected %h got %h", $time, want, m_axis_tdata[30:0]);
          error_count++;
        end
        if (m_axis_tdata[31] !== 1'b0) begin
          $display("%0t: pad bit expected 0 got %b", $time, m_axis_tdata[31]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // first three outputs after reset follow straight from the default words
    probe_rows = '{
      '{OP_NEXT,   32'h00000000, 1'b1, 31'h6b8b4567},
      '{OP_NEXT,   32'hffffffff, 1'b1, 31'h327b23c6},
      '{OP_NEXT,   32'h5a5a5a5a, 1'b1, 31'h643c9869},
      '{OP_RESEED, 32'h00000000, 1'b0, 31'h0},
      '{OP_NEXT,   32'ha5a5a5a5, 1'b0, 31'h0},
      '{OP_NEXT,   32'h00000000, 1'b0, 31'h0},
      '{OP_RESEED, 32'hffffffff, 1'b0, 31'h0},
      '{OP_NEXT,   32'hffffffff, 1'b0, 31'h0},
      '{OP_RESEED, 32'h80000000, 1'b0, 31'h0},
      '{OP_NEXT,   32'h00000000, 1'b0, 31'h0},
      '{OP_RESEED, 32'h7fffffff, 1'b0, 31'h0},
      '{OP_NEXT,   32'h12345678, 1'b0, 31'h0},
      '{OP_NEXT,   32'h87654321, 1'b0, 31'h0},
      '{OP_RESEED, 32'h00000001, 1'b0, 31'h0},
      '{OP_NEXT,   32'h00000000, 1'b0, 31'h0},
      '{OP_RESEED, 32'd127773,   1'b0, 31'h0},
      '{OP_NEXT,   32'h00000000, 1'b0, 31'h0},
      '{OP_RESEED, 32'd123459876, 1'b0, 31'h0},
      '{OP_NEXT,   32'hffffffff, 1'b0, 31'h0},
      '{OP_RESEED, 32'hdeadbeef, 1'b0, 31'h0},
      '{OP_RESEED, 32'h00000005, 1'b0, 31'h0},
      '{OP_NEXT,   32'h00000000, 1'b0, 31'h0},
      '{OP_NEXT,   32'hffffffff, 1'b0, 31'h0}
    };
    reset_table();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rcv_idle_pct = 30;
    foreach (probe_rows[i])
      offer_item(probe_rows[i].op, probe_rows[i].seed, probe_rows[i].known, probe_rows[i].value);
    drain();

    random_phase(17, 52);
    random_phase(52, 17);
    // long output hold while items keep coming
    hold_req = 1'b1;
    random_phase(0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d next requests and %0d reseeds, %0d results checked", next_count,
             reseed_count, checked_count);
    $display("covered extreme and zero seeds, back-to-back reseeds, a long output hold");
    if (error_count == 0 && expected_values.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
